// ===== sv/kmgw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the knob-to-gain/mute parameter writer.
// Depends on nothing; every other file of the block imports it.
package kmgw_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DEADBAND_W = 8;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned SLOPE_W = 24;
  localparam int unsigned PROD_W = SLOPE_W + SAMPLE_W;
  localparam int unsigned GAIN_W = OFFSET_W - 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TARGET_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Depth of the request queue between front and back.
  localparam int unsigned CMD_DEPTH = 4;

  // Register reset values.
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd2;
  localparam logic [SAMPLE_W-1:0] MUTE_THR_RST = 12'd2855;
  localparam logic [SAMPLE_W-1:0] KNEE_THR_RST = 12'd1861;
  localparam logic [OFFSET_W-1:0] UPPER_OFF_RST = 32'd885837005;
  localparam logic [SLOPE_W-1:0] UPPER_SLOPE_RST = 24'd302776;
  localparam logic [OFFSET_W-1:0] LOWER_OFF_RST = 32'd2478060855;
  localparam logic [SLOPE_W-1:0] LOWER_SLOPE_RST = 24'd1157975;

  // Mute on is 1.0 in 9.23 fixed point.
  localparam logic [VALUE_W-1:0] MUTE_ON_WORD = 32'h0080_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND    = 3'd0,
    REG_MUTE_THR    = 3'd1,
    REG_KNEE_THR    = 3'd2,
    REG_UPPER_OFF   = 3'd3,
    REG_UPPER_SLOPE = 3'd4,
    REG_LOWER_OFF   = 3'd5,
    REG_LOWER_SLOPE = 3'd6
  } cfg_reg_t;

  // Write targets.
  localparam logic [TARGET_W-1:0] TGT_CH1_MUTE = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_CH2_MUTE = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_CH1_GAIN = 2'd2;
  localparam logic [TARGET_W-1:0] TGT_CH2_GAIN = 2'd3;

  // Current register contents.
  typedef struct packed {
    logic [DEADBAND_W-1:0] deadband;
    logic [SAMPLE_W-1:0]   mute_threshold;
    logic [SAMPLE_W-1:0]   knee_threshold;
    logic [OFFSET_W-1:0]   upper_offset;
    logic [SLOPE_W-1:0]    upper_slope;
    logic [OFFSET_W-1:0]   lower_offset;
    logic [SLOPE_W-1:0]    lower_slope;
  } cfg_t;

  // One classified request from front to back.
  typedef struct packed {
    logic              mute;
    logic              upper;
    logic [PROD_W-1:0] prod;
  } cmd_t;

endpackage

// ===== sv/knob_to_gain_mute_writer_core.sv =====
`timescale 1ns / 1ps
// Top level of the knob-to-gain/mute parameter writer.
// Depends on kmgw_pkg, kmgw_cfg_regs, kmgw_front, kmgw_cmd_fifo and kmgw_back.
//
//   Channel   Handshake          Payload
//   in_       in_push / in_full  in_sample
//   out_      out_pop / out_empty out_target, out_value, out_last
//   cfg_      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// A sample is taken whenever the request queue has room; a kept sample then gives
// two writes (mute) or four writes (gain), one per cycle while out_pop is high, as
// stepped by the back end's write sequencer.
// A sample's first write shows once its queue entry is loaded into the back end.
// Reset loads the register defaults, clears the last accepted sample and empties the queue.
// A stalled result side fills the queue, after which in_full holds the input side.
module knob_to_gain_mute_writer_core import kmgw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = CMD_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  in_full,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [TARGET_W-1:0]   out_target,
  output logic [VALUE_W-1:0]    out_value,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  cmd_t q_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Registers accept a write every cycle.
  assign cfg_ready = 1'b1;

  kmgw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  kmgw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_full   (in_full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  kmgw_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  kmgw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_target (out_target),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

// ===== sv/kmgw_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the knob-to-gain/mute writer.
// Depends on kmgw_pkg for the register indexes and the cfg_t bundle.
module kmgw_cfg_regs import kmgw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write; an unknown index leaves everything as it is.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_DEADBAND:    cfg_nxt.deadband = wr_data[DEADBAND_W-1:0];
        REG_MUTE_THR:    cfg_nxt.mute_threshold = wr_data[SAMPLE_W-1:0];
        REG_KNEE_THR:    cfg_nxt.knee_threshold = wr_data[SAMPLE_W-1:0];
        REG_UPPER_OFF:   cfg_nxt.upper_offset = wr_data[OFFSET_W-1:0];
        REG_UPPER_SLOPE: cfg_nxt.upper_slope = wr_data[SLOPE_W-1:0];
        REG_LOWER_OFF:   cfg_nxt.lower_offset = wr_data[OFFSET_W-1:0];
        REG_LOWER_SLOPE: cfg_nxt.lower_slope = wr_data[SLOPE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband       <= DEADBAND_RST;
      cfg_r.mute_threshold <= MUTE_THR_RST;
      cfg_r.knee_threshold <= KNEE_THR_RST;
      cfg_r.upper_offset   <= UPPER_OFF_RST;
      cfg_r.upper_slope    <= UPPER_SLOPE_RST;
      cfg_r.lower_offset   <= LOWER_OFF_RST;
      cfg_r.lower_slope    <= LOWER_SLOPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/kmgw_front.sv =====
`timescale 1ns / 1ps
// Front end: deadband filter, mute/segment classification and slope product.
// Depends on kmgw_pkg; feeds kmgw_cmd_fifo.
module kmgw_front import kmgw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_push,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                in_full,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_cmd
);

  logic [SAMPLE_W-1:0] last_acc_r;
  logic [SAMPLE_W-1:0] last_acc_nxt;
  logic [SAMPLE_W-1:0] diff;
  logic                accept;
  logic                keep;
  logic                upper;
  logic [SLOPE_W-1:0]  slope;

  // Distance from the last accepted sample.
  assign diff = (in_sample > last_acc_r) ? (in_sample - last_acc_r)
                                         : (last_acc_r - in_sample);

  // A sample is taken whenever the queue has room; it is kept only if it moved far enough.
  assign accept = in_push && !q_full;
  assign keep   = accept && (diff != '0) && (diff >= {{(SAMPLE_W-DEADBAND_W){1'b0}}, cfg.deadband});
  assign in_full = q_full;

  // Segment choice and slope product; the queue entry registers the product.
  assign upper = (in_sample >= cfg.knee_threshold);
  assign slope = upper ? cfg.upper_slope : cfg.lower_slope;

  always_comb begin
    q_cmd.mute  = (in_sample >= cfg.mute_threshold);
    q_cmd.upper = upper;
    q_cmd.prod  = PROD_W'(slope) * PROD_W'(in_sample);
  end
  assign q_push = keep;

  assign last_acc_nxt = keep ? in_sample : last_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_acc_r <= '0;
    end else begin
      last_acc_r <= last_acc_nxt;
    end
  end

endmodule

// ===== sv/kmgw_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short request queue between the front and back ends.
// Depends on kmgw_pkg for the cmd_t entry type.
module kmgw_cmd_fifo import kmgw_pkg::*; #(
  parameter int unsigned DEPTH = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  cmd_t           mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/kmgw_back.sv =====
`timescale 1ns / 1ps
// Back end: finishes the gain word and emits the parameter writes of one request.
// Depends on kmgw_pkg; drains kmgw_cmd_fifo.
module kmgw_back import kmgw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  cmd_t                q_head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [TARGET_W-1:0] out_target,
  output logic [VALUE_W-1:0]  out_value,
  output logic                out_last
);

  logic                busy_r, busy_nxt;
  logic                mute_r, mute_nxt;
  logic [TARGET_W-1:0] step_r, step_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [OFFSET_W-1:0] offset;
  logic [OFFSET_W-1:0] diff;
  logic                positive;
  logic                done;
  logic                load;

  // Gain word: offset minus product, clamped at zero, then down to 2^-23 units.
  assign offset   = q_head.upper ? cfg.upper_offset : cfg.lower_offset;
  assign positive = (PROD_W'(offset) > q_head.prod);
  assign diff     = offset - q_head.prod[OFFSET_W-1:0];

  // Result currently on the ports.
  assign out_empty  = !busy_r;
  assign out_target = step_r;
  assign out_last   = mute_r ? (step_r == TGT_CH2_MUTE) : (step_r == TGT_CH2_GAIN);
  always_comb begin
    if (mute_r) begin
      out_value = MUTE_ON_WORD;
    end else if (step_r == TGT_CH1_GAIN || step_r == TGT_CH2_GAIN) begin
      out_value = {{(VALUE_W-GAIN_W){1'b0}}, gain_r};
    end else begin
      out_value = '0;
    end
  end

  // Take the next request once the last write of this one leaves.
  assign done  = busy_r && out_pop && out_last;
  assign load  = (!busy_r || done) && !q_empty;
  assign q_pop = load;

  always_comb begin
    busy_nxt = busy_r;
    mute_nxt = mute_r;
    step_nxt = step_r;
    gain_nxt = gain_r;
    if (load) begin
      busy_nxt = 1'b1;
      mute_nxt = q_head.mute;
      step_nxt = TGT_CH1_MUTE;
      gain_nxt = positive ? diff[OFFSET_W-1:8] : '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_pop) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= TGT_CH1_MUTE;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mute_r <= mute_nxt;
    gain_r <= gain_nxt;
  end

endmodule
